@@ src/ptt_pkg.sv @@
package ptt_pkg;

   // field widths
   localparam int ID_W     = 16;
   localparam int PER_W    = 32;
   localparam int TIME_W   = 64;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 3;

   // default table depth
   localparam int MAX_TASKS_DEF = 8;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE    = 3'd4;

   // one table entry as held in the task memory
   typedef struct packed {
      logic [ID_W-1:0]   task_id;
      logic [PER_W-1:0]  period;
      logic [TIME_W-1:0] deadline;
   } entry_type;

   // add two times, clamp at the top of the time range
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

@@ src/ptt_remainder.sv @@
module ptt_remainder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [ptt_pkg::TIME_W-1:0] dividend,
   input  logic [ptt_pkg::PER_W-1:0]  divisor,
   output logic                       done,
   output logic [ptt_pkg::PER_W-1:0]  rem
);
   import ptt_pkg::*;

   localparam int CNT_W = $clog2(TIME_W);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0] dvd_ff, dvd_in;
   logic [PER_W-1:0] rem_ff, rem_in;
   logic [PER_W:0]   shifted;
   logic [PER_W:0]   trial;
   logic             fits;

   // one restoring step: bring in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, dvd_ff[TIME_W-1]};
      trial   = shifted - {1'b0, divisor};
      fits    = shifted >= {1'b0, divisor};
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(TIME_W - 1);
         dvd_in = dividend;
         rem_in = '0;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
         rem_in = fits ? trial[PER_W-1:0] : shifted[PER_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

@@ src/periodic_task_table_core.sv @@
// Periodic task table: holds up to MAX_TASKS tasks (id, period, next deadline).
// Input item: start with busy low accepts req_kind, req_task_id, req_period_us
// and req_now_us. Kind 0 registers a task (update period if the id is present,
// else append, else report full); kind 1 is a tick that fires every due task
// and moves its deadline past now by whole periods.
// Results: rsp_strobe marks one result per cycle on the rsp_ ports; the
// receiver cannot stall, so each result is shown for exactly one cycle.
// rsp_last marks the final result of an item; a tick with nothing due gives
// one nothing-due result.
// Walk: the table sits in one synchronous memory read one slot at a time;
// each slot visited is first read (S_SCAN), then evaluated (S_EVAL). A register
// item ends at the slot that holds the id, or after the last stored slot.
// For each fired task a tick starts the bit-serial remainder unit, one quotient
// bit per cycle over the 64-bit time difference, waits in S_DIV for its done,
// and then writes the deadline back in S_ADV.
// Reset clears the task count; the memory needs no clearing since only slots
// below the count are read.
module periodic_task_table_core #(
   parameter int MAX_TASKS = ptt_pkg::MAX_TASKS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  logic [ptt_pkg::ID_W-1:0]     req_task_id,
   input  logic [ptt_pkg::PER_W-1:0]    req_period_us,
   input  logic [ptt_pkg::TIME_W-1:0]   req_now_us,
   output logic                         rsp_strobe,
   output logic [ptt_pkg::STATUS_W-1:0] rsp_status,
   output logic [ptt_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [ptt_pkg::ID_W-1:0]     rsp_fired_id,
   output logic                         rsp_last
);
   import ptt_pkg::*;

   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_ADV  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              kind_ff, kind_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [PER_W-1:0]  per_ff, per_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] base_ff, base_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]  pend_slot_ff, pend_slot_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                rsp_last_ff, rsp_last_in;

   // task memory with registered read data
   entry_type         task_mem [MAX_TASKS];
   entry_type         rd_ff;
   logic              rd_en;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   logic              at_end;
   logic              borrow;
   logic [TIME_W-1:0] diff;
   logic              div_go;
   logic              div_done;
   logic [PER_W-1:0]  div_rem;

   ptt_remainder u_rem (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (diff),
      .divisor  (rd_ff.period),
      .done     (div_done),
      .rem      (div_rem)
   );

   assign at_end = (idx_ff == count_ff);
   assign {borrow, diff} = {1'b0, now_ff} - {1'b0, rd_ff.deadline};

   // sequence the walk over the table
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      per_in        = per_ff;
      now_in        = now_ff;
      base_in       = base_ff;
      pend_vld_in   = pend_vld_ff;
      pend_slot_in  = pend_slot_ff;
      pend_id_in    = pend_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_data       = rd_ff;
      div_go        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in     = req_kind;
               id_in       = req_task_id;
               per_in      = (req_period_us == '0) ? PER_W'(1) : req_period_us;
               now_in      = req_now_us;
               idx_in      = '0;
               pend_vld_in = 1'b0;
               state_in    = S_SCAN;
            end
         end

         S_SCAN: begin
            if (at_end) begin
               state_in    = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_last_in = 1'b1;
               if (kind_ff) begin
                  // close the tick: flush the held result or report nothing due
                  if (pend_vld_ff) begin
                     rsp_status_in = ST_DUE;
                     rsp_slot_in   = SLOT_W'(pend_slot_ff);
                     rsp_id_in     = pend_id_ff;
                  end else begin
                     rsp_status_in = ST_NONE;
                     rsp_slot_in   = '0;
                     rsp_id_in     = '0;
                  end
               end else if (count_ff == CNT_W'(MAX_TASKS)) begin
                  rsp_status_in = ST_FULL;
                  rsp_slot_in   = '0;
                  rsp_id_in     = '0;
               end else begin
                  // append the new task at the end of the table
                  wr_en            = 1'b1;
                  wr_addr          = count_ff[IDX_W-1:0];
                  wr_data.task_id  = id_ff;
                  wr_data.period   = per_ff;
                  wr_data.deadline = sat_add(now_ff, TIME_W'(per_ff));
                  count_in         = count_ff + 1'b1;
                  rsp_status_in    = ST_ADDED;
                  rsp_slot_in      = SLOT_W'(count_ff[IDX_W-1:0]);
                  rsp_id_in        = id_ff;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            if (!kind_ff) begin
               if (rd_ff.task_id == id_ff) begin
                  // known id: replace the period, keep the deadline
                  wr_en          = 1'b1;
                  wr_data.period = per_ff;
                  rsp_strobe_in  = 1'b1;
                  rsp_status_in  = ST_UPDATED;
                  rsp_slot_in    = SLOT_W'(idx_ff[IDX_W-1:0]);
                  rsp_id_in      = id_ff;
                  rsp_last_in    = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SCAN;
               end
            end else if (!borrow) begin
               // due: release the earlier fired task, hold this one back
               div_go = 1'b1;
               if (pend_vld_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_DUE;
                  rsp_slot_in   = SLOT_W'(pend_slot_ff);
                  rsp_id_in     = pend_id_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_vld_in  = 1'b1;
               pend_slot_in = idx_ff[IDX_W-1:0];
               pend_id_in   = rd_ff.task_id;
               state_in     = S_DIV;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end

         S_DIV: begin
            // last whole period at or before now
            if (div_done) begin
               base_in  = now_ff - TIME_W'(div_rem);
               state_in = S_ADV;
            end
         end

         S_ADV: begin
            wr_en            = 1'b1;
            wr_data.deadline = sat_add(base_ff, TIME_W'(rd_ff.period));
            idx_in           = idx_ff + 1'b1;
            state_in         = S_SCAN;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      per_ff        <= per_in;
      now_ff        <= now_in;
      base_ff       <= base_in;
      pend_slot_ff  <= pend_slot_in;
      pend_id_ff    <= pend_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // task memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         task_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= task_mem[idx_ff[IDX_W-1:0]];
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TASKS))
      else $error("task count beyond table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not start a walk");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && div_done |-> div_rem < rd_ff.period)
      else $error("remainder not below period");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_NONE |-> rsp_last && rsp_slot == '0)
      else $error("nothing-due result malformed");

   a_mid_due: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> rsp_status == ST_DUE)
      else $error("non-final result that is not a fired task");

endmodule
